// ===== hw/rtl/mr_pkg.sv =====
`timescale 1ns / 1ps

package mr_pkg;

  // Sizes of the symbol set, the string and the arithmetic.
  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_LENGTH  = 8;
  localparam int VALUE_WIDTH = 20;
  localparam int ENTRY_WIDTH = 19;
  localparam int SYM_WIDTH   = 8;
  localparam int IDX_WIDTH   = $clog2(MAX_SYMBOLS);
  localparam int PLACE_WIDTH = $clog2(MAX_LENGTH);
  localparam int ADDR_WIDTH  = IDX_WIDTH + PLACE_WIDTH;
  localparam int TABLE_DEPTH = MAX_SYMBOLS * MAX_LENGTH;
  localparam int ALPH_WIDTH  = MAX_SYMBOLS * SYM_WIDTH;

  // Configuration port.
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALPHABET_SIZE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALPHABET_HIGH = 2'd2;

  localparam logic [4:0]  SIZE_RESET = 5'd15;
  localparam logic [63:0] LOW_RESET  = 64'd5208208757389214273;
  localparam logic [63:0] HIGH_RESET = 64'd22322617059592777;

  // Operation codes.
  localparam logic OP_UNRANK = 1'b0;
  localparam logic OP_RANK   = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [VALUE_WIDTH-1:0] value;
    logic [SYM_WIDTH-1:0]   symbol;
  } in_t;

  typedef struct packed {
    logic [SYM_WIDTH-1:0]   out_symbol;
    logic [VALUE_WIDTH-1:0] out_value;
    logic                   error;
    logic                   last;
  } out_t;

  typedef logic [TABLE_DEPTH-1:0][ENTRY_WIDTH-1:0] table_t;

  // Pascal recurrence: entry (c, v) is C(c+v, v+1), stored at address c*MAX_LENGTH+v.
  function automatic table_t build_table();
    table_t t;
    t = '0;
    for (int c = 0; c < MAX_SYMBOLS; c++) begin
      for (int v = 0; v < MAX_LENGTH; v++) begin
        if (c == 0) begin
          t[c*MAX_LENGTH+v] = '0;
        end else if (v == 0) begin
          t[c*MAX_LENGTH+v] = ENTRY_WIDTH'(c);
        end else begin
          t[c*MAX_LENGTH+v] = t[c*MAX_LENGTH+v-1] + t[(c-1)*MAX_LENGTH+v];
        end
      end
    end
    return t;
  endfunction

  localparam table_t PLACE_TABLE = build_table();

  // Symbol byte for an index out of the packed alphabet.
  function automatic logic [SYM_WIDTH-1:0] sym_byte(input logic [ALPH_WIDTH-1:0] alph,
                                                    input logic [IDX_WIDTH-1:0]  idx);
    return alph[idx*SYM_WIDTH +: SYM_WIDTH];
  endfunction

endpackage

// ===== hw/rtl/multiset_rank_unrank_top.sv =====
`timescale 1ns / 1ps

// Channel   Signals                          Beat
// in        in_valid, in_ready, in_item      one op: unrank value or one rank symbol
// out       out_valid, out_ready, out_item   one symbol, or one finished rank
// cfg       cfg_we, cfg_index, cfg_data      one register write, no wait
//
// Unrank works place by place (S symbols in use, L = S/2 places): each place
// sweeps the table ROM once over all symbols, one read per cycle, then emits.
// Rank matches each symbol with a ROM read, then accumulates. The
// symbol that completes the string is followed by an emit step for the sum.
// Reset is synchronous; the table is constant and needs no clearing.
// A full output register stalls the sequencer only when it has a new beat.
module multiset_rank_unrank_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mr_pkg::in_t                        in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mr_pkg::out_t                       out_item,
  input  logic                               cfg_we,
  input  logic [mr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import mr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_U_SEARCH,
    S_U_DRAIN,
    S_U_EMIT,
    S_R_ADD,
    S_R_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [4:0]  alphabet_size;
  logic [63:0] alphabet_low;
  logic [63:0] alphabet_high;

  // Unrank working registers.
  logic [VALUE_WIDTH-1:0] rem;
  logic [PLACE_WIDTH-1:0] place;
  logic [IDX_WIDTH-1:0]   cnt;
  logic [IDX_WIDTH-1:0]   cnt_d;
  logic                   rd_valid;
  logic [IDX_WIDTH-1:0]   pick;
  logic [ENTRY_WIDTH-1:0] pick_entry;

  // Rank state and the latched decision for the symbol in flight.
  logic [3:0]             place_count;
  logic [IDX_WIDTH-1:0]   previous_index;
  logic                   have_previous;
  logic [VALUE_WIDTH-1:0] running_sum;
  logic                   rank_failed;
  logic                   r_add;
  logic                   r_fail;
  logic [IDX_WIDTH-1:0]   r_idx;

  logic [4:0]             size_eff;
  logic [3:0]             len;
  logic [ALPH_WIDTH-1:0]  alph;
  logic                   match_found;
  logic [IDX_WIDTH-1:0]   match_idx;
  logic [PLACE_WIDTH-1:0] rank_place;
  logic [ADDR_WIDTH-1:0]  rom_addr;
  logic [ENTRY_WIDTH-1:0] rom_data;
  logic                   slot_free;
  logic                   out_load;
  logic                   search_last;
  logic                   sym_ok;
  logic [3:0]             pc_next;
  logic [VALUE_WIDTH-1:0] rem_after;

  // Effective alphabet size (2..16) and string length.
  always_comb begin
    if (alphabet_size < 5'd2) begin
      size_eff = 5'd2;
    end else if (alphabet_size > 5'(MAX_SYMBOLS)) begin
      size_eff = 5'(MAX_SYMBOLS);
    end else begin
      size_eff = alphabet_size;
    end
  end

  assign len  = size_eff[4:1];
  assign alph = {alphabet_high, alphabet_low};

  mr_sym_match u_match (
    .alph   (alph),
    .size   (size_eff),
    .symbol (in_item.symbol),
    .found  (match_found),
    .idx    (match_idx)
  );

  // Place of the incoming rank symbol; beyond the string it falls to place zero.
  assign rank_place = (place_count < len) ? PLACE_WIDTH'(len - 4'd1 - place_count) : '0;
  assign rom_addr   = (state == S_U_SEARCH) ? {cnt, place} : {match_idx, rank_place};

  mr_table_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign in_ready    = (state == S_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign out_load    = ((state == S_U_EMIT) || (state == S_R_EMIT)) && slot_free;
  assign search_last = ({1'b0, cnt} == (size_eff - 5'd1));
  assign sym_ok      = match_found && !(have_previous && (match_idx > previous_index));
  assign pc_next     = place_count + 4'd1;
  assign rem_after   = rem - VALUE_WIDTH'(pick_entry);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= SIZE_RESET;
      alphabet_low  <= LOW_RESET;
      alphabet_high <= HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHABET_SIZE: alphabet_size <= cfg_data[4:0];
        CFG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        CFG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Search pipeline: keep the largest symbol whose entry fits the remainder.
  always_ff @(posedge clk) begin
    rd_valid <= (state == S_U_SEARCH);
    cnt_d    <= cnt;
  end

  // Sequencer, rank state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      place_count   <= '0;
      previous_index <= '0;
      have_previous <= 1'b0;
      running_sum   <= '0;
      rank_failed   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (rd_valid && ({1'b0, rom_data} <= rem)) begin
        pick       <= cnt_d;
        pick_entry <= rom_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.op == OP_UNRANK) begin
              rem            <= in_item.value;
              place          <= PLACE_WIDTH'(len - 4'd1);
              cnt            <= '0;
              pick           <= '0;
              pick_entry     <= '0;
              place_count    <= '0;
              previous_index <= '0;
              have_previous  <= 1'b0;
              running_sum    <= '0;
              rank_failed    <= 1'b0;
              state          <= S_U_SEARCH;
            end else begin
              r_add <= !rank_failed && sym_ok;
              r_fail <= !rank_failed && !sym_ok;
              r_idx <= match_idx;
              state <= S_R_ADD;
            end
          end
        end
        S_U_SEARCH: begin
          cnt <= cnt + 1'b1;
          if (search_last) begin
            state <= S_U_DRAIN;
          end
        end
        S_U_DRAIN: begin
          state <= S_U_EMIT;
        end
        S_U_EMIT: begin
          if (slot_free) begin
            out_item.out_symbol <= sym_byte(alph, pick);
            out_item.out_value  <= '0;
            out_item.error      <= (place == '0) && (rem_after != '0);
            out_item.last       <= (place == '0);
            rem                 <= rem_after;
            if (place == '0) begin
              state <= S_IDLE;
            end else begin
              place      <= place - 1'b1;
              cnt        <= '0;
              pick       <= '0;
              pick_entry <= '0;
              state      <= S_U_SEARCH;
            end
          end
        end
        S_R_ADD: begin
          if (r_add) begin
            running_sum    <= running_sum + VALUE_WIDTH'(rom_data);
            previous_index <= r_idx;
            have_previous  <= 1'b1;
          end
          if (r_fail) begin
            rank_failed <= 1'b1;
          end
          place_count <= pc_next;
          if ((pc_next >= len) || (pc_next == '0)) begin
            state <= S_R_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_R_EMIT: begin
          if (slot_free) begin
            out_item.out_symbol <= '0;
            out_item.out_value  <= rank_failed ? '0 : running_sum;
            out_item.error      <= rank_failed;
            out_item.last       <= 1'b1;
            place_count         <= '0;
            previous_index      <= '0;
            have_previous       <= 1'b0;
            running_sum         <= '0;
            rank_failed         <= 1'b0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mr_table_rom.sv =====
`timescale 1ns / 1ps

module mr_table_rom (
  input  logic                          clk,
  input  logic [mr_pkg::ADDR_WIDTH-1:0]  addr,
  output logic [mr_pkg::ENTRY_WIDTH-1:0] data
);
  import mr_pkg::*;

  // Synchronous (registered) read of the constant place table.
  always_ff @(posedge clk) begin
    data <= PLACE_TABLE[addr];
  end

endmodule

// ===== hw/rtl/mr_sym_match.sv =====
`timescale 1ns / 1ps

module mr_sym_match (
  input  logic [mr_pkg::ALPH_WIDTH-1:0] alph,
  input  logic [4:0]                    size,
  input  logic [mr_pkg::SYM_WIDTH-1:0]  symbol,
  output logic                          found,
  output logic [mr_pkg::IDX_WIDTH-1:0]  idx
);
  import mr_pkg::*;

  // Compare against every symbol in use; the lowest matching index wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int c = MAX_SYMBOLS - 1; c >= 0; c--) begin
      if ((5'(c) < size) && (alph[c*SYM_WIDTH +: SYM_WIDTH] == symbol)) begin
        found = 1'b1;
        idx   = IDX_WIDTH'(c);
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mr_pkg::*;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  in_t                        in_item;
  logic                       out_valid;
  logic                       out_ready;
  out_t                       out_item;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  multiset_rank_unrank_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies as the block should hold them.
  logic [4:0]  cur_size;
  logic [63:0] cur_low;
  logic [63:0] cur_high;

  // Partial rank in progress.
  logic [3:0]  places_seen = '0;
  logic [3:0]  last_index  = '0;
  bit          have_last;
  logic [19:0] partial_sum = '0;
  bit          rank_bad;

  // Binomial entries C(c+v, v+1), indexed by symbol and place.
  logic [ENTRY_WIDTH-1:0] entry_rom [MAX_SYMBOLS][MAX_LENGTH];

  in_t  ops_q[$];
  out_t due_beats[$];
  out_t want_beat;
  int   errors;
  int   queued;
  int   send_idle_pct;
  int   stall_pct;
  int   offered_cnt;
  int   taken_cnt;

  function automatic int unsigned choose(int n, int k);
    longint unsigned r;
    r = 1;
    // Each step leaves r = C(n-k+i, i), so the division is exact.
    for (int i = 1; i <= k; i++) r = r * (n - k + i) / i;
    return 32'(r);
  endfunction

  // Symbol count in use, saturated to the supported range.
  function automatic int used_symbols();
    int s;
    s = cur_size;
    if (s < 2) s = 2;
    if (s > MAX_SYMBOLS) s = MAX_SYMBOLS;
    return s;
  endfunction

  function automatic int places();
    int n;
    n = used_symbols() / 2;
    if (n > MAX_LENGTH) n = MAX_LENGTH;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic logic [7:0] symbol_of(int idx);
    logic [127:0] a;
    a = {cur_high, cur_low};
    return a[idx*8 +: 8];
  endfunction

  // Rank of the string made of the highest symbol in every place.
  function automatic int unsigned top_rank();
    int unsigned t;
    t = 0;
    for (int v = 0; v < places(); v++) t += entry_rom[used_symbols()-1][v];
    return t;
  endfunction

  function automatic void clear_rank_state();
    places_seen = '0;
    last_index  = '0;
    have_last   = 0;
    partial_sum = '0;
    rank_bad    = 0;
  endfunction

  // Works out the result beats that one accepted input beat causes.
  function automatic void predict_beat(in_t it);
    int          s;
    int          n;
    int          v;
    int          pick;
    int          idx;
    bit          found;
    logic [19:0] rem;
    out_t        r;
    s = used_symbols();
    n = places();
    if (it.op == OP_UNRANK) begin
      rem = it.value;
      clear_rank_state();
      // Greedy pick per place, highest place first.
      for (int i = 0; i < n; i++) begin
        v = n - 1 - i;
        pick = 0;
        for (int c = 0; c < s; c++) if (entry_rom[c][v] <= rem) pick = c;
        rem = rem - entry_rom[pick][v];
        r = '0;
        r.out_symbol = symbol_of(pick);
        if (i == n - 1) begin
          r.error = (rem != 0);
          r.last  = 1'b1;
        end
        due_beats.push_back(r);
      end
    end else begin
      // After a failure the remaining symbols are only counted.
      if (!rank_bad) begin
        found = 0;
        idx = 0;
        for (int c = 0; c < s; c++) begin
          if (!found && symbol_of(c) == it.symbol) begin
            idx = c;
            found = 1;
          end
        end
        if (!found || (have_last && idx > last_index)) begin
          rank_bad = 1;
        end else begin
          v = (places_seen < n) ? n - 1 - places_seen : 0;
          partial_sum = partial_sum + entry_rom[idx][v];
          last_index = 4'(idx);
          have_last = 1;
        end
      end
      places_seen = places_seen + 1'b1;
      if (places_seen >= n || places_seen == 0) begin
        r = '0;
        r.out_value = rank_bad ? '0 : partial_sum;
        r.error     = rank_bad;
        r.last      = 1'b1;
        due_beats.push_back(r);
        clear_rank_state();
      end
    end
  endfunction

  // Sixteen distinct random symbol bytes.
  function automatic logic [127:0] distinct_alphabet();
    logic [127:0] a;
    logic [7:0]   b;
    bit           dup;
    a = '0;
    for (int i = 0; i < 16; i++) begin
      do begin
        b = 8'($urandom_range(255));
        dup = 0;
        for (int j = 0; j < i; j++) if (a[j*8 +: 8] == b) dup = 1;
      end while (dup);
      a[i*8 +: 8] = b;
    end
    return a;
  endfunction

  task automatic push_unrank(input logic [19:0] val);
    in_t it;
    it.op     = OP_UNRANK;
    it.value  = val;
    it.symbol = 8'($urandom_range(255));
    ops_q.push_back(it);
    queued++;
  endtask

  task automatic push_rank(input logic [7:0] sym);
    in_t it;
    it.op     = OP_RANK;
    it.value  = 20'($urandom);
    it.symbol = sym;
    ops_q.push_back(it);
    queued++;
  endtask

  // Symbol string for the current setting. Flavor 0 is well formed, 1 has one
  // random byte, 2 has one increasing step, 3 stops short of the full length.
  task automatic push_string(input int flavor);
    int         s;
    int         n;
    int         idx;
    int         bad;
    logic [7:0] sym;
    s = used_symbols();
    n = places();
    idx = $urandom_range(s - 1);
    bad = (n > 1) ? $urandom_range(n - 1, 1) : 0;
    for (int i = 0; i < n; i++) begin
      if (i > 0) idx = $urandom_range(idx);
      if (flavor == 2 && i == bad && idx < s - 1) idx = $urandom_range(s - 1, idx + 1);
      sym = symbol_of(idx);
      if (flavor == 1 && i == bad) sym = 8'($urandom_range(255));
      if (flavor == 3 && i == bad) break;
      push_rank(sym);
    end
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      if ($urandom_range(99) < 70) push_unrank(20'($urandom_range(top_rank())));
      else push_unrank(20'($urandom));
    end else if (r < 75) begin
      push_string(0);
    end else if (r < 85) begin
      push_string(1);
    end else if (r < 93) begin
      push_string(2);
    end else begin
      push_string(3);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALPHABET_SIZE: cur_size = data[4:0];
      CFG_ALPHABET_LOW:  cur_low  = data;
      CFG_ALPHABET_HIGH: cur_high = data;
      default: ;
    endcase
  endtask

  // Hold off until every result is in, then give the block time to settle.
  task automatic drain();
    while (ops_q.size() != 0 || in_valid || due_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: presents the next item once the previous beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      in_item   <= '0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || taken_cnt == offered_cnt) begin
        if (ops_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= ops_q.pop_front();
          in_valid <= 1'b1;
          offered_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predicts on each input beat and checks each output beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_beat(in_item);
        taken_cnt++;
      end
      if (out_valid && out_ready) begin
        if (due_beats.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected: symbol %h value %h error %b last %b",
                   $time, out_item.out_symbol, out_item.out_value, out_item.error,
                   out_item.last);
        end else begin
          want_beat = due_beats.pop_front();
          if (out_item.out_symbol !== want_beat.out_symbol ||
              out_item.out_value !== want_beat.out_value ||
              out_item.error !== want_beat.error || out_item.last !== want_beat.last) begin
            errors++;
            $display("%0t: mismatch: expected symbol %h value %h error %b last %b, ",
                     $time, want_beat.out_symbol, want_beat.out_value, want_beat.error,
                     want_beat.last,
                     "got symbol %h value %h error %b last %b",
                     out_item.out_symbol, out_item.out_value, out_item.error,
                     out_item.last);
          end
        end
      end
    end
  end

  initial begin
    logic [127:0] alph;
    int           sz;
    int           goal;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    queued    = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    for (int c = 0; c < MAX_SYMBOLS; c++) begin
      for (int v = 0; v < MAX_LENGTH; v++) begin
        entry_rom[c][v] = ENTRY_WIDTH'(choose(c + v, v + 1));
      end
    end
    cur_size = SIZE_RESET;
    cur_low  = LOW_RESET;
    cur_high = HIGH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: value extremes, the top rank and one past it, and a
    // partial rank cut off by an unrank.
    push_unrank(0);
    push_unrank(20'hFFFFF);
    push_unrank(20'(top_rank()));
    push_unrank(20'(top_rank() + 1));
    push_rank("H");
    push_rank("G");
    push_unrank(20'($urandom_range(1000)));
    drain();

    // Size below range saturates to two symbols, one place.
    write_reg(CFG_ALPHABET_SIZE, 64'd0);
    push_rank("A");
    push_rank("B");
    push_rank(8'hFF);
    push_unrank(1);
    push_unrank(2);
    drain();

    // Two places: increasing pair, unknown byte, equal pair, then a size
    // change that leaves a partial rank already at the new length.
    write_reg(CFG_ALPHABET_SIZE, 64'd5);
    push_rank("C");
    push_rank("D");
    push_rank(8'h00);
    push_rank("A");
    push_rank("B");
    push_rank("B");
    push_rank("C");
    drain();
    write_reg(CFG_ALPHABET_SIZE, 64'd2);
    push_rank("A");
    drain();

    // Size above range, with symbol 15 a duplicate of symbol 0.
    write_reg(CFG_ALPHABET_SIZE, 64'd31);
    write_reg(CFG_ALPHABET_HIGH, {8'h41, 56'h4F4E4D4C4B4A49});
    push_unrank(20'(top_rank()));
    push_rank("A");
    push_unrank(20'hFFFFF);
    drain();

    // Random phases over the idling modes and several settings.
    for (int p = 0; p < 8; p++) begin
      send_idle_pct = (p / 2 == 1) ? 78 : (p / 2 == 3) ? 20 : 0;
      stall_pct     = (p / 2 == 2) ? 78 : (p / 2 == 3) ? 20 : 0;
      case (p)
        0: sz = 16;
        1: sz = 2;
        5: sz = $urandom_range(31, 17);
        default: sz = $urandom_range(15, 3);
      endcase
      alph = distinct_alphabet();
      if (p == 3) alph = {64'h0, {64{1'b1}}};
      if (p == 6) alph = {{64{1'b1}}, 64'h0};
      write_reg(CFG_ALPHABET_SIZE, 64'(sz));
      write_reg(CFG_ALPHABET_LOW, alph[63:0]);
      write_reg(CFG_ALPHABET_HIGH, alph[127:64]);
      goal = queued + 36;
      while (queued < goal) random_item();
      drain();
    end

    if (errors == 0) begin
      $display("** multiset_rank_unrank_top: PASSED **");
    end else begin
      $display("** multiset_rank_unrank_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** multiset_rank_unrank_top: FAILED **");
    $finish;
  end

endmodule
